@@ hdl/scc_pkg.sv @@
// Shared constants for the strongly connected components unit.
`default_nettype none
package scc_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 256;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);
    localparam int LW = EW + 1;
    localparam int CW = 7;
    localparam logic [LW-1:0] NullLink = LW'(MaxEdges);
    localparam logic [CW-1:0] CountLimit = CW'(MaxVertices > 64 ? 64 : MaxVertices);
    localparam logic CmdLoad = 1'b0;
    localparam logic CmdRun  = 1'b1;
endpackage
`default_nettype wire

@@ hdl/strongly_connected_components_unit.sv @@
// Top level: edge loader and Tarjan component search over RAM-held state.
// Edge load: busy stays high while a load is pending, so the next load waits until busy falls;
// entry, head/tail and own link are written while it is pending, a tail link in the next cycle.
// Run: edge visits, vertex opens and closes, vertex pops, root tests and the clear of the edge
// store each take their own run of states, paced by serial registered RAM reads.
// Results leave one per strobe cycle; the receiver cannot stall. Reset empties all lists,
// clears the drop flag and sets the vertex count to 64.
`default_nettype none
module strongly_connected_components_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       cmd,
    input  wire logic [5:0] edge_source,
    input  wire logic [5:0] edge_target,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    output logic            result_valid,
    output logic [5:0]      vertex_id,
    output logic [5:0]      component_id,
    output logic            last_of_component,
    output logic            last_of_run,
    output logic            edges_dropped
);
    localparam int VW = scc_pkg::VW;
    localparam int EW = scc_pkg::EW;
    localparam int LW = scc_pkg::LW;
    localparam int CW = scc_pkg::CW;
    localparam int FW = VW + LW;
    localparam int MaxV = scc_pkg::MaxVertices;

    typedef enum logic [4:0] {
        S_IDLE, S_ROOT, S_OPEN, S_OPEN2, S_TOP, S_TOPW, S_LOWW, S_EDGE, S_EDGEW,
        S_VIS, S_VISW, S_CLOSE, S_CLOSEW, S_POP, S_POPW, S_RET, S_RETW,
        S_RET2, S_CLEAR
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [LW-1:0] loaded_reg;
    logic          drop_reg;
    logic [MaxV-1:0] head_valid_reg;
    logic [MaxV-1:0] visited_reg, pending_reg;
    logic [VW:0]   visit_reg;
    logic [VW:0]   pdepth_reg, fdepth_reg;
    logic [VW-1:0] root_reg, v_reg, w_reg, u_reg;
    logic [LW-1:0] cur_reg;
    logic [VW-1:0] low_v_reg;
    logic [VW-1:0] comp_reg;
    logic [VW:0]   emitted_reg;

    // effective count
    logic [CW-1:0] n_eff;
    always_comb
    begin
        n_eff = count_reg;
        if (n_eff == '0) n_eff = CW'(1);
        if (n_eff > scc_pkg::CountLimit) n_eff = scc_pkg::CountLimit;
    end

    // RAM ports
    logic          et_we;  logic [EW-1:0] et_wa, et_ra; logic [VW-1:0] et_wd, et_rd;
    logic          nl_we;  logic [EW-1:0] nl_wa, nl_ra; logic [LW-1:0] nl_wd, nl_rd;
    logic          hd_we;  logic [VW-1:0] hd_wa, hd_ra; logic [2*LW-1:0] hd_wd, hd_rd;
    logic          vo_we;  logic [VW-1:0] vo_wa, vo_ra; logic [VW-1:0] vo_wd, vo_rd;
    logic          ll_we;  logic [VW-1:0] ll_wa, ll_ra; logic [VW-1:0] ll_wd, ll_rd;
    logic          ps_we;  logic [VW-1:0] ps_wa, ps_ra; logic [VW-1:0] ps_wd, ps_rd;
    logic          fr_we;  logic [VW-1:0] fr_wa, fr_ra; logic [FW-1:0] fr_wd, fr_rd;

    scc_ram #(.Width(VW), .Depth(scc_pkg::MaxEdges)) u_et (.clk, .we(et_we),
        .waddr(et_wa), .wdata(et_wd), .raddr(et_ra), .rdata(et_rd));
    scc_ram #(.Width(LW), .Depth(scc_pkg::MaxEdges)) u_nl (.clk, .we(nl_we),
        .waddr(nl_wa), .wdata(nl_wd), .raddr(nl_ra), .rdata(nl_rd));
    scc_ram #(.Width(2*LW), .Depth(MaxV)) u_hd (.clk, .we(hd_we),
        .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
    scc_ram #(.Width(VW), .Depth(MaxV)) u_vo (.clk, .we(vo_we),
        .waddr(vo_wa), .wdata(vo_wd), .raddr(vo_ra), .rdata(vo_rd));
    scc_ram #(.Width(VW), .Depth(MaxV)) u_ll (.clk, .we(ll_we),
        .waddr(ll_wa), .wdata(ll_wd), .raddr(ll_ra), .rdata(ll_rd));
    scc_ram #(.Width(VW), .Depth(MaxV)) u_ps (.clk, .we(ps_we),
        .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));
    scc_ram #(.Width(FW), .Depth(MaxV)) u_fr (.clk, .we(fr_we),
        .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));

    // Head/tail of a list: stored pair, null while its valid bit is clear. Read head/tail
    // at accept; write entry, own null link and head/tail next cycle; link the old tail
    // in the cycle after that.
    logic          ld_p_reg;
    logic [VW-1:0] ld_src_reg, ld_dst_reg;
    logic [EW-1:0] ld_e_reg;
    logic          lk_p_reg;
    logic [EW-1:0] lk_a_reg, lk_d_reg;
    logic [VW-1:0] hd_ra_reg;

    logic accept;
    logic load_ok;
    logic [LW-1:0] hd_first, hd_last;
    logic [LW-1:0] fr_cur;
    logic [VW-1:0] fr_v;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE) || ld_p_reg;
    assign load_ok  = ({1'b0, edge_source} < n_eff) && ({1'b0, edge_target} < n_eff)
                      && (loaded_reg < scc_pkg::NullLink);
    assign hd_first = head_valid_reg[hd_ra_reg] ? hd_rd[2*LW-1:LW] : scc_pkg::NullLink;
    assign hd_last  = head_valid_reg[hd_ra_reg] ? hd_rd[LW-1:0]    : scc_pkg::NullLink;
    assign fr_v     = fr_rd[FW-1:LW];
    assign fr_cur   = fr_rd[LW-1:0];

    always_comb
    begin
        et_we = 1'b0; et_wa = ld_e_reg; et_wd = ld_dst_reg; et_ra = cur_reg[EW-1:0];
        nl_we = 1'b0; nl_wa = ld_e_reg; nl_wd = scc_pkg::NullLink; nl_ra = cur_reg[EW-1:0];
        hd_we = 1'b0; hd_wa = ld_src_reg; hd_wd = '0; hd_ra = edge_source;
        vo_we = 1'b0; vo_wa = w_reg; vo_wd = visit_reg[VW-1:0]; vo_ra = w_reg;
        ll_we = 1'b0; ll_wa = w_reg; ll_wd = visit_reg[VW-1:0]; ll_ra = w_reg;
        ps_we = 1'b0; ps_wa = pdepth_reg[VW-1:0]; ps_wd = w_reg;
        ps_ra = VW'(pdepth_reg - 1'b1);
        fr_we = 1'b0; fr_wa = fdepth_reg[VW-1:0]; fr_wd = {w_reg, hd_first};
        fr_ra = VW'(fdepth_reg - 1'b1);
        if (ld_p_reg)
        begin
            et_we = 1'b1;
            nl_we = 1'b1;
            hd_we = 1'b1;
            hd_wd = {(hd_last == scc_pkg::NullLink) ? {1'b0, ld_e_reg} : hd_first,
                     {1'b0, ld_e_reg}};
        end
        if (lk_p_reg)
        begin
            nl_we = 1'b1;
            nl_wa = lk_a_reg;
            nl_wd = {1'b0, lk_d_reg};
        end
        case (state_reg)
            S_OPEN:   hd_ra = w_reg;
            S_OPEN2:
            begin
                vo_we = 1'b1; ll_we = 1'b1; ps_we = 1'b1; fr_we = 1'b1;
            end
            S_TOPW:   ll_ra = fr_v;
            S_EDGE:
            begin
                fr_we = 1'b1; fr_wa = VW'(fdepth_reg - 1'b1); fr_wd = {v_reg, nl_rd};
            end
            S_VIS:    vo_ra = w_reg;
            S_VISW:
            begin
                ll_we = (vo_rd < low_v_reg) && pending_reg[w_reg];
                ll_wa = v_reg; ll_wd = vo_rd;
            end
            S_CLOSE:  vo_ra = v_reg;
            S_RET:    fr_ra = VW'(fdepth_reg - 2'd2);
            S_RET2:   ll_ra = fr_v;
            S_RETW:
            begin
                ll_we = low_v_reg < ll_rd; ll_wa = u_reg; ll_wd = low_v_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= CW'(64);
            loaded_reg        <= '0;
            drop_reg          <= 1'b0;
            head_valid_reg    <= '0;
            visited_reg       <= '0;
            pending_reg       <= '0;
            visit_reg         <= '0;
            pdepth_reg        <= '0;
            fdepth_reg        <= '0;
            ld_p_reg          <= 1'b0;
            ld_src_reg        <= '0;
            ld_dst_reg        <= '0;
            ld_e_reg          <= '0;
            lk_p_reg          <= 1'b0;
            lk_a_reg          <= '0;
            lk_d_reg          <= '0;
            hd_ra_reg         <= '0;
            result_valid      <= 1'b0;
            vertex_id         <= '0;
            component_id      <= '0;
            last_of_component <= 1'b0;
            last_of_run       <= 1'b0;
            edges_dropped     <= 1'b0;
            emitted_reg       <= '0;
            comp_reg          <= '0;
            root_reg          <= '0;
            v_reg             <= '0;
            w_reg             <= '0;
            u_reg             <= '0;
            cur_reg           <= '0;
            low_v_reg         <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            hd_ra_reg    <= hd_ra;
            if (cfg_we) count_reg <= cfg_wdata;
            ld_p_reg <= 1'b0;
            lk_p_reg <= 1'b0;
            if (ld_p_reg)
            begin
                head_valid_reg[ld_src_reg] <= 1'b1;
                lk_p_reg <= hd_last != scc_pkg::NullLink;
                lk_a_reg <= hd_last[EW-1:0];
                lk_d_reg <= ld_e_reg;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd == scc_pkg::CmdLoad)
                    begin
                        if (load_ok)
                        begin
                            ld_p_reg   <= 1'b1;
                            ld_src_reg <= edge_source;
                            ld_dst_reg <= edge_target;
                            ld_e_reg   <= loaded_reg[EW-1:0];
                            loaded_reg <= loaded_reg + 1'b1;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    else if (accept)
                    begin
                        root_reg    <= '0;
                        visited_reg <= '0;
                        pending_reg <= '0;
                        visit_reg   <= '0;
                        pdepth_reg  <= '0;
                        fdepth_reg  <= '0;
                        comp_reg    <= '0;
                        emitted_reg <= '0;
                        state_reg   <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if ({1'b0, root_reg} >= n_eff || emitted_reg == (VW+1)'(n_eff))
                    begin
                        state_reg <= S_CLEAR;
                    end
                    else if (visited_reg[root_reg])
                    begin
                        root_reg <= root_reg + 1'b1;
                    end
                    else
                    begin
                        w_reg     <= root_reg;
                        state_reg <= S_OPEN;
                    end
                end
                S_OPEN: state_reg <= S_OPEN2;
                S_OPEN2:
                begin
                    visited_reg[w_reg] <= 1'b1;
                    pending_reg[w_reg] <= 1'b1;
                    visit_reg  <= visit_reg + 1'b1;
                    pdepth_reg <= pdepth_reg + 1'b1;
                    fdepth_reg <= fdepth_reg + 1'b1;
                    state_reg  <= S_TOP;
                end
                S_TOP: state_reg <= S_TOPW;
                S_TOPW:
                begin
                    v_reg     <= fr_v;
                    cur_reg   <= fr_cur;
                    state_reg <= S_LOWW;
                end
                S_LOWW:
                begin
                    low_v_reg <= ll_rd;
                    state_reg <= cur_reg[LW-1] ? S_CLOSE : S_EDGE;
                end
                S_EDGE: state_reg <= S_EDGEW;
                S_EDGEW:
                begin
                    cur_reg   <= nl_rd;
                    w_reg     <= et_rd;
                    if ({1'b0, et_rd} >= n_eff) state_reg <= S_TOP;
                    else if (!visited_reg[et_rd]) state_reg <= S_OPEN;
                    else state_reg <= S_VIS;
                end
                S_VIS: state_reg <= S_VISW;
                S_VISW: state_reg <= S_TOP;
                S_CLOSE: state_reg <= S_CLOSEW;
                S_CLOSEW:
                begin
                    state_reg <= (low_v_reg == vo_rd) ? S_POP : S_RET;
                end
                S_POP: state_reg <= S_POPW;
                S_POPW:
                begin
                    pending_reg[ps_rd] <= 1'b0;
                    pdepth_reg         <= pdepth_reg - 1'b1;
                    result_valid       <= 1'b1;
                    vertex_id          <= ps_rd;
                    component_id       <= comp_reg;
                    last_of_component  <= ps_rd == v_reg;
                    last_of_run        <= emitted_reg + 1'b1 == (VW+1)'(n_eff);
                    edges_dropped      <= drop_reg;
                    emitted_reg        <= emitted_reg + 1'b1;
                    if (ps_rd == v_reg)
                    begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= S_RET;
                    end
                    else
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_RET:
                begin
                    fdepth_reg <= fdepth_reg - 1'b1;
                    if (fdepth_reg == (VW+1)'(1))
                    begin
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        state_reg <= S_RET2;
                    end
                end
                S_RET2:
                begin
                    u_reg     <= fr_v;
                    state_reg <= S_RETW;
                end
                S_RETW: state_reg <= S_TOP;
                S_CLEAR:
                begin
                    head_valid_reg <= '0;
                    loaded_reg     <= '0;
                    drop_reg       <= 1'b0;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> emitted_reg <= (VW+1)'(n_eff))
        else $error("more results than vertices");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_run) |-> last_of_component)
        else $error("run ended inside a component");
    assert property (@(posedge clk) disable iff (!rst_n)
        ld_p_reg |-> !$past(ld_p_reg) || $past(state_reg) == S_IDLE)
        else $error("load outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ld_p_reg && lk_p_reg))
        else $error("two link writes in one cycle");
endmodule
`default_nettype wire

@@ hdl/scc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module scc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
